@@ hw/rtl/rmopd_pkg.sv @@
// Package with shared constants, types and the microcode table of the orbit period detector.
`default_nettype none
package rmopd_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 28;
    localparam int ORBIT_DEPTH = 64;
    localparam int ADDR_W      = $clog2(ORBIT_DEPTH);
    localparam int DIV_STEPS   = WORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int EPS_W       = 31;
    localparam int ITER_W      = 16;
    localparam int PLIM_W      = 7;
    localparam int LAG_W       = 6;
    localparam int COLOUR_W    = 12;
    localparam int CFG_W       = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int NREG        = 14;
    localparam int RF_AW       = $clog2(NREG);
    localparam int PC_W        = 6;

    localparam logic [ITER_W-1:0]   RST_MAX_ITER = ITER_W'(100);
    localparam logic [PLIM_W-1:0]   RST_PER_LIM  = PLIM_W'(10);
    localparam logic [EPS_W-1:0]    RST_EPS      = EPS_W'(26844);
    localparam logic [COLOUR_W-1:0] COLOUR_STEP  = COLOUR_W'(20);
    localparam logic [COLOUR_W-1:0] COLOUR_BASE  = COLOUR_W'(128);

    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] QONE = WORD_BITS'(64'd1 << FRAC_BITS);
    localparam logic signed [WORD_BITS-1:0] QK427 =
        WORD_BITS'(((64'd4 << FRAC_BITS) + 64'd13) / 64'd27);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PER_LIM  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_EPS      = CFG_IDX_W'(2);

    typedef enum logic [3:0] {
        OP_NOP, OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_STORE, OP_LOAD, OP_LATCH, OP_CMP
    } t_op;

    typedef enum logic [4:0] {
        S_AR = 5'd0, S_AI = 5'd1, S_XR = 5'd2, S_XI = 5'd3, S_CR = 5'd4, S_CI = 5'd5,
        S_U0 = 5'd6, S_U1 = 5'd7, S_U2 = 5'd8, S_U3 = 5'd9, S_U4 = 5'd10, S_U5 = 5'd11,
        S_U6 = 5'd12, S_U7 = 5'd13, S_ONE = 5'd14, S_K = 5'd15, S_ZERO = 5'd16
    } t_src;

    typedef struct packed {
        t_op  op;
        t_src dst;
        t_src sa;
        t_src sb;
    } t_uop;

    typedef struct packed {
        t_uop              uop;
        logic              load_point;
        logic              div_start;
        logic              store_we;
        logic [ADDR_W-1:0] ram_addr;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic dist_lt;
    } t_stat;

    typedef enum logic [2:0] {
        ST_IDLE, ST_INIT, ST_ITER, ST_DIVW, ST_CHECK, ST_DONE
    } t_state;

    localparam logic [PC_W-1:0] PC_INIT_LAST = PC_W'(14);
    localparam logic [PC_W-1:0] PC_ITER_BEG  = PC_W'(15);
    localparam logic [PC_W-1:0] PC_ITER_LAST = PC_W'(47);
    localparam logic [PC_W-1:0] PC_CHK_BEG   = PC_W'(48);
    localparam logic [PC_W-1:0] PC_CHK_LAST  = PC_W'(54);

    function automatic t_uop mk(input t_op op, input t_src d, input t_src a, input t_src b);
        t_uop u;
        u.op  = op;
        u.dst = d;
        u.sa  = a;
        u.sb  = b;
        return u;
    endfunction

    // Setup of x = a and c = a^2 (1 - a), one map step, and one lag test.
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = mk(OP_NOP, S_U0, S_U0, S_U0);
        unique case (pc)
            6'd0:  u = mk(OP_ADD, S_XR, S_AR, S_ZERO);
            6'd1:  u = mk(OP_ADD, S_XI, S_AI, S_ZERO);
            6'd2:  u = mk(OP_MUL, S_U0, S_AR, S_AR);
            6'd3:  u = mk(OP_MUL, S_U1, S_AI, S_AI);
            6'd4:  u = mk(OP_SUB, S_U2, S_U0, S_U1);
            6'd5:  u = mk(OP_MUL, S_U0, S_AR, S_AI);
            6'd6:  u = mk(OP_ADD, S_U3, S_U0, S_U0);
            6'd7:  u = mk(OP_SUB, S_U4, S_ONE, S_AR);
            6'd8:  u = mk(OP_SUB, S_U5, S_ZERO, S_AI);
            6'd9:  u = mk(OP_MUL, S_U0, S_U2, S_U4);
            6'd10: u = mk(OP_MUL, S_U1, S_U3, S_U5);
            6'd11: u = mk(OP_SUB, S_CR, S_U0, S_U1);
            6'd12: u = mk(OP_MUL, S_U0, S_U2, S_U5);
            6'd13: u = mk(OP_MUL, S_U1, S_U3, S_U4);
            6'd14: u = mk(OP_ADD, S_CI, S_U0, S_U1);
            6'd15: u = mk(OP_STORE, S_U0, S_U0, S_U0);
            6'd16: u = mk(OP_SUB, S_U4, S_XR, S_ONE);
            6'd17: u = mk(OP_MUL, S_U0, S_XR, S_XR);
            6'd18: u = mk(OP_MUL, S_U1, S_XI, S_XI);
            6'd19: u = mk(OP_SUB, S_U2, S_U0, S_U1);
            6'd20: u = mk(OP_MUL, S_U0, S_XR, S_XI);
            6'd21: u = mk(OP_ADD, S_U3, S_U0, S_U0);
            6'd22: u = mk(OP_MUL, S_U0, S_U2, S_U4);
            6'd23: u = mk(OP_MUL, S_U1, S_U3, S_XI);
            6'd24: u = mk(OP_SUB, S_U5, S_U0, S_U1);
            6'd25: u = mk(OP_MUL, S_U0, S_U2, S_XI);
            6'd26: u = mk(OP_MUL, S_U1, S_U3, S_U4);
            6'd27: u = mk(OP_ADD, S_U3, S_U0, S_U1);
            6'd28: u = mk(OP_ADD, S_U2, S_U5, S_CR);
            6'd29: u = mk(OP_ADD, S_U4, S_U3, S_CI);
            6'd30: u = mk(OP_MUL, S_U0, S_AR, S_U2);
            6'd31: u = mk(OP_MUL, S_U1, S_AI, S_U4);
            6'd32: u = mk(OP_SUB, S_U6, S_U0, S_U1);
            6'd33: u = mk(OP_MUL, S_U0, S_AR, S_U4);
            6'd34: u = mk(OP_MUL, S_U1, S_AI, S_U2);
            6'd35: u = mk(OP_ADD, S_U7, S_U0, S_U1);
            6'd36: u = mk(OP_ADD, S_U5, S_U5, S_K);
            6'd37: u = mk(OP_MUL, S_U0, S_U5, S_U5);
            6'd38: u = mk(OP_MUL, S_U1, S_U3, S_U3);
            6'd39: u = mk(OP_ADD, S_U2, S_U0, S_U1);
            6'd40: u = mk(OP_MUL, S_U0, S_U6, S_U5);
            6'd41: u = mk(OP_MUL, S_U1, S_U7, S_U3);
            6'd42: u = mk(OP_ADD, S_U4, S_U0, S_U1);
            6'd43: u = mk(OP_MUL, S_U0, S_U7, S_U5);
            6'd44: u = mk(OP_MUL, S_U1, S_U6, S_U3);
            6'd45: u = mk(OP_SUB, S_U6, S_U0, S_U1);
            6'd46: u = mk(OP_DIV, S_XR, S_U4, S_U2);
            6'd47: u = mk(OP_DIV, S_XI, S_U6, S_U2);
            6'd48: u = mk(OP_LOAD, S_U0, S_U0, S_U0);
            6'd49: u = mk(OP_LATCH, S_U6, S_U0, S_U0);
            6'd50: u = mk(OP_SUB, S_U2, S_XR, S_U6);
            6'd51: u = mk(OP_SUB, S_U3, S_XI, S_U7);
            6'd52: u = mk(OP_MUL, S_U0, S_U2, S_U2);
            6'd53: u = mk(OP_MUL, S_U1, S_U3, S_U3);
            6'd54: u = mk(OP_CMP, S_U0, S_U0, S_U1);
            default: u = mk(OP_NOP, S_U0, S_U0, S_U0);
        endcase
        return u;
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_w(
        input logic signed [2*WORD_BITS-1:0] v);
        logic signed [2*WORD_BITS-1:0] hi;
        logic signed [2*WORD_BITS-1:0] lo;
        hi = WMAX;
        lo = WMIN;
        if (v > hi) return WMAX;
        if (v < lo) return WMIN;
        return v[WORD_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rmopd_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none
module rmopd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/rmopd_div.sv @@
// Restoring fixed-point divider, one quotient bit per cycle, floored and saturated.
`default_nettype none
module rmopd_div
    import rmopd_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [WORD_BITS-1:0] i_num,
    input  wire logic signed [WORD_BITS-1:0] i_den,
    output logic                             o_done,
    output logic signed [WORD_BITS-1:0]      o_quo
);
    logic                     r_busy;
    logic                     r_fin;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic [WORD_BITS-1:0]     r_rem;
    logic [DIV_STEPS-1:0]     r_quo;
    logic [WORD_BITS-1:0]     r_den;
    logic                     r_neg;
    logic                     r_nz;
    logic [WORD_BITS-1:0]     mag;
    logic [WORD_BITS:0]       rem_sh;
    logic                     ge;
    logic [DIV_STEPS:0]       q_adj;
    logic [DIV_STEPS:0]       lim;
    logic [WORD_BITS-1:0]     q_sat;

    assign mag    = i_num[WORD_BITS-1] ? WORD_BITS'(-i_num) : WORD_BITS'(i_num);
    assign rem_sh = {r_rem, r_quo[DIV_STEPS-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {mag, {FRAC_BITS{1'b0}}};
            r_den <= i_den;
            r_neg <= i_num[WORD_BITS-1];
            r_nz  <= i_num != '0;
        end else if (r_busy) begin
            r_rem <= ge ? WORD_BITS'(rem_sh - {1'b0, r_den}) : rem_sh[WORD_BITS-1:0];
            r_quo <= {r_quo[DIV_STEPS-2:0], ge};
        end
    end

    // Negative quotients round toward minus infinity: bump the magnitude on a remainder.
    always_comb begin
        q_adj = {1'b0, r_quo} + (DIV_STEPS+1)'(r_neg && (r_rem != '0));
        lim   = r_neg ? (DIV_STEPS+1)'({1'b1, {(WORD_BITS-1){1'b0}}})
                      : (DIV_STEPS+1)'({1'b0, {(WORD_BITS-1){1'b1}}});
        q_sat = (q_adj > lim) ? lim[WORD_BITS-1:0] : q_adj[WORD_BITS-1:0];
        if (r_den == '0) begin
            o_quo = r_neg ? WMIN : (r_nz ? WMAX : '0);
        end else begin
            o_quo = r_neg ? WORD_BITS'(-q_sat) : q_sat;
        end
    end

    assign o_done = r_fin;
endmodule
`default_nettype wire

@@ hw/rtl/rmopd_dp.sv @@
// Datapath: register file, shared multiplier and adder, divider and orbit memory.
`default_nettype none
module rmopd_dp
    import rmopd_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cmd                        i_cmd,
    input  wire logic signed [WORD_BITS-1:0] i_point_re,
    input  wire logic signed [WORD_BITS-1:0] i_point_im,
    input  wire logic [EPS_W-1:0]            i_eps,
    output t_stat                            o_stat
);
    logic signed [WORD_BITS-1:0]   r_rf [NREG];
    logic signed [WORD_BITS-1:0]   va;
    logic signed [WORD_BITS-1:0]   vb;
    logic signed [2*WORD_BITS-1:0] prod;
    logic signed [2*WORD_BITS-1:0] ea;
    logic signed [2*WORD_BITS-1:0] eb;
    logic signed [WORD_BITS-1:0]   mul_res;
    logic signed [WORD_BITS-1:0]   add_res;
    logic signed [WORD_BITS-1:0]   sub_res;
    logic signed [WORD_BITS:0]     dsum;
    logic [2*WORD_BITS-1:0]        rdata;
    logic                          div_done;
    logic signed [WORD_BITS-1:0]   div_quo;

    function automatic logic signed [WORD_BITS-1:0] rd(input t_src s);
        priority case (s)
            S_ONE:   return QONE;
            S_K:     return QK427;
            S_ZERO:  return '0;
            default: return r_rf[RF_AW'(s)];
        endcase
    endfunction

    always_comb begin
        va      = rd(i_cmd.uop.sa);
        vb      = rd(i_cmd.uop.sb);
        prod    = va * vb;
        mul_res = sat_w(prod >>> FRAC_BITS);
        ea      = va;
        eb      = vb;
        add_res = sat_w(ea + eb);
        sub_res = sat_w(ea - eb);
        dsum    = {r_rf[RF_AW'(S_U0)][WORD_BITS-1], r_rf[RF_AW'(S_U0)]}
                + {r_rf[RF_AW'(S_U1)][WORD_BITS-1], r_rf[RF_AW'(S_U1)]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            r_rf[RF_AW'(S_AR)] <= i_point_re;
            r_rf[RF_AW'(S_AI)] <= i_point_im;
        end else begin
            unique case (i_cmd.uop.op)
                OP_MUL:   r_rf[RF_AW'(i_cmd.uop.dst)] <= mul_res;
                OP_ADD:   r_rf[RF_AW'(i_cmd.uop.dst)] <= add_res;
                OP_SUB:   r_rf[RF_AW'(i_cmd.uop.dst)] <= sub_res;
                OP_LATCH: begin
                    r_rf[RF_AW'(S_U6)] <= rdata[2*WORD_BITS-1:WORD_BITS];
                    r_rf[RF_AW'(S_U7)] <= rdata[WORD_BITS-1:0];
                end
                OP_DIV: begin
                    if (div_done) begin
                        r_rf[RF_AW'(i_cmd.uop.dst)] <= div_quo;
                    end
                end
                default: ;
            endcase
        end
    end

    rmopd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (va),
        .i_den   (vb),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    rmopd_ram #(
        .WIDTH (2 * WORD_BITS),
        .DEPTH (ORBIT_DEPTH)
    ) u_orbit (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store_we),
        .i_addr  (i_cmd.ram_addr),
        .i_wdata ({r_rf[RF_AW'(S_XR)], r_rf[RF_AW'(S_XI)]}),
        .o_rdata (rdata)
    );

    assign o_stat.div_done = div_done;
    assign o_stat.dist_lt  = dsum < $signed({{(WORD_BITS+1-EPS_W){1'b0}}, i_eps});
endmodule
`default_nettype wire

@@ hw/rtl/rmopd_ctrl.sv @@
// Controller: sequences the microcode through setup, map steps and the lag search.
`default_nettype none
module rmopd_ctrl
    import rmopd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [ITER_W-1:0]   i_max_iter,
    input  wire logic [PLIM_W-1:0]   i_per_lim,
    input  wire t_stat               i_stat,
    output t_cmd                     o_cmd,
    output logic                     o_busy,
    output logic                     o_valid,
    output logic                     o_hit,
    output logic [LAG_W-1:0]         o_lag,
    output logic [COLOUR_W-1:0]      o_colour_code
);
    t_state              r_state, n_state;
    logic [PC_W-1:0]     r_pc;
    logic [ITER_W-1:0]   r_iter;
    logic [ITER_W-1:0]   r_n;
    logic [ITER_W-1:0]   r_base;
    logic [PLIM_W-1:0]   r_p;
    logic [PLIM_W-1:0]   r_j;
    logic                r_hit;
    logic [LAG_W-1:0]    r_lag;
    t_uop                uop;
    logic [PLIM_W-1:0]   p_clamp;
    logic                last_iter;
    logic                last_j;

    assign uop       = uop_rom(r_pc);
    assign last_iter = ITER_W'(r_iter + 1'b1) == r_n;
    assign last_j    = PLIM_W'(r_j + 1'b1) == r_p;

    always_comb begin
        p_clamp = (i_per_lim > PLIM_W'(ORBIT_DEPTH)) ? PLIM_W'(ORBIT_DEPTH) : i_per_lim;
        if (ITER_W'(p_clamp) > i_max_iter) begin
            p_clamp = i_max_iter[PLIM_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_INIT;
            ST_INIT:  if (r_pc == PC_INIT_LAST) n_state = (r_n == '0) ? ST_DONE : ST_ITER;
            ST_ITER:  if (uop.op == OP_DIV) n_state = ST_DIVW;
            ST_DIVW: begin
                if (i_stat.div_done) begin
                    if (r_pc == PC_ITER_LAST && last_iter) begin
                        n_state = (r_p == '0) ? ST_DONE : ST_CHECK;
                    end else begin
                        n_state = ST_ITER;
                    end
                end
            end
            ST_CHECK: begin
                if (r_pc == PC_CHK_LAST && (i_stat.dist_lt || last_j)) n_state = ST_DONE;
            end
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_iter  <= '0;
            r_j     <= '0;
            r_hit   <= 1'b0;
            r_lag   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_pc   <= '0;
                        r_iter <= '0;
                        r_j    <= '0;
                        r_hit  <= 1'b0;
                        r_lag  <= '0;
                        r_n    <= i_max_iter;
                        r_p    <= p_clamp;
                        r_base <= i_max_iter - ITER_W'(p_clamp);
                    end
                end
                ST_INIT: r_pc <= (r_pc == PC_INIT_LAST) ? PC_ITER_BEG : r_pc + 1'b1;
                ST_ITER: if (uop.op != OP_DIV) r_pc <= r_pc + 1'b1;
                ST_DIVW: begin
                    if (i_stat.div_done) begin
                        if (r_pc == PC_ITER_LAST) begin
                            r_iter <= r_iter + 1'b1;
                            r_pc   <= last_iter ? PC_CHK_BEG : PC_ITER_BEG;
                        end else begin
                            r_pc <= r_pc + 1'b1;
                        end
                    end
                end
                ST_CHECK: begin
                    if (r_pc == PC_CHK_LAST) begin
                        if (i_stat.dist_lt) begin
                            r_hit <= 1'b1;
                            r_lag <= r_j[LAG_W-1:0];
                        end else begin
                            r_j  <= r_j + 1'b1;
                            r_pc <= PC_CHK_BEG;
                        end
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                ST_DONE: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cmd.uop        = mk(OP_NOP, S_U0, S_U0, S_U0);
        o_cmd.load_point = 1'b0;
        o_cmd.div_start  = 1'b0;
        o_cmd.store_we   = 1'b0;
        o_cmd.ram_addr   = ADDR_W'(r_iter - r_base);
        unique case (r_state)
            ST_IDLE:  o_cmd.load_point = i_start;
            ST_INIT:  o_cmd.uop = uop;
            ST_ITER: begin
                o_cmd.uop       = uop;
                o_cmd.div_start = uop.op == OP_DIV;
                o_cmd.store_we  = (uop.op == OP_STORE) && (r_iter >= r_base);
            end
            ST_DIVW:  o_cmd.uop = uop;
            ST_CHECK: begin
                o_cmd.uop      = uop;
                o_cmd.ram_addr = ADDR_W'(r_p - r_j - 1'b1);
            end
            ST_DONE:  ;
            default:  ;
        endcase
    end

    assign o_busy        = r_state != ST_IDLE;
    assign o_valid       = r_state == ST_DONE;
    assign o_hit         = r_hit;
    assign o_lag         = r_lag;
    assign o_colour_code = r_hit ? COLOUR_W'(COLOUR_W'(r_lag) * COLOUR_STEP + COLOUR_BASE)
                                 : '1;

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_busy)
        else $error("result strobe not followed by idle");
    a_start_only_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("block left idle without a request");
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> r_state == ST_DIVW)
        else $error("divider finished outside the wait state");
    a_miss_lag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_lag == '0))
        else $error("lag nonzero on a miss");
endmodule
`default_nettype wire

@@ hw/rtl/rational_map_orbit_period_detect.sv @@
// Top level of the orbit period detector: configuration registers and controller/datapath.
`default_nettype none
// A request carries one parameter point a (i_point_re, i_point_im, signed Q4.28).
// It is taken at a rising edge where start is high and busy is low. The block
// then sets x = a, applies the rational map max_iterations times, keeps the last
// period_limit iterates in a 64-entry orbit memory, and searches lags from the
// newest stored iterate for a squared distance below eps_squared.
// The result (o_hit, o_lag, o_colour_code) is shown for exactly one cycle with
// o_valid high; the receiver cannot stall it, so no result is ever held back.
// Each map step runs 31 microcode operations on one shared 32x32 multiplier
// and adder, plus two quotients (issue, 60 steps of one bit, result) on a
// shared restoring divider; that divider sets the rate.
// One request is in flight at a time; busy stays high until the result cycle.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while the
// block is idle; unknown indexes are ignored. A synchronous active-low reset
// returns the controller to idle and loads the register defaults
// (100 iterations, period limit 10, threshold 0.0001). The orbit memory is not
// cleared; only entries written for the current point are ever read.
module rational_map_orbit_period_detect
    import rmopd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [31:0]   i_point_re,
    input  wire logic signed [31:0]   i_point_im,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_valid,
    output logic                      o_hit,
    output logic [LAG_W-1:0]          o_lag,
    output logic signed [COLOUR_W-1:0] o_colour_code
);
    logic [ITER_W-1:0] r_max_iter;
    logic [PLIM_W-1:0] r_per_lim;
    logic [EPS_W-1:0]  r_eps;
    t_cmd              cmd;
    t_stat             stat;
    logic [COLOUR_W-1:0] colour;

    // Configuration registers; the user must only issue writes while the block is idle; it is not checked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= RST_MAX_ITER;
            r_per_lim  <= RST_PER_LIM;
            r_eps      <= RST_EPS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                CFG_PER_LIM:  r_per_lim  <= i_cfg_data[PLIM_W-1:0];
                CFG_EPS:      r_eps      <= i_cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    rmopd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_max_iter    (r_max_iter),
        .i_per_lim     (r_per_lim),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_lag         (o_lag),
        .o_colour_code (colour)
    );

    // The point enters at word width; with 32-bit words no saturation is needed.
    rmopd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_point_re (WORD_BITS'(i_point_re)),
        .i_point_im (WORD_BITS'(i_point_im)),
        .i_eps      (r_eps),
        .o_stat     (stat)
    );

    assign o_colour_code = $signed(colour);
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the rational-map orbit period detector.
`default_nettype none
module testbench
    import rmopd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // A generous cycle limit.
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int RANDOM_REQUESTS = 120;
    localparam int PHASE_LEN = 15;

    typedef struct {
        longint re;
        longint im;
    } t_cval;

    typedef struct packed {
        logic                      hit;
        logic [LAG_W-1:0]          lag;
        logic signed [COLOUR_W-1:0] colour;
    } t_outcome;

    typedef enum logic {ROW_CFG, ROW_POINT} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
        logic signed [31:0]     re;
        logic signed [31:0]     im;
        logic                   known;
        t_outcome               outcome;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic signed [31:0]         i_point_re;
    logic signed [31:0]         i_point_im;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [CFG_W-1:0]           i_cfg_data;
    logic                       o_valid;
    logic                       o_hit;
    logic [LAG_W-1:0]           o_lag;
    logic signed [COLOUR_W-1:0] o_colour_code;

    // Shadow copy of the configuration registers.
    logic [ITER_W-1:0] iter_setting;
    logic [PLIM_W-1:0] plim_setting;
    logic [EPS_W-1:0]  eps_setting;

    t_outcome pending_outcomes[$];
    int       mismatch_count;
    int       cycle_count;

    rational_map_orbit_period_detect i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_point_re   (i_point_re),
        .i_point_im   (i_point_im),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_lag        (o_lag),
        .o_colour_code(o_colour_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Fixed-point predictor. All values live in longint, and every factor of a
    // product stays inside the signed word range, so every product fits in 64 bits.
    // ---------------------------------------------------------------------
    function automatic longint clamp_word(input longint v);
        if (v > longint'(WMAX)) return longint'(WMAX);
        if (v < longint'(WMIN)) return longint'(WMIN);
        return v;
    endfunction

    // Product floored to the fraction width; the arithmetic shift floors.
    function automatic longint fx_mul(input longint a, input longint b);
        return clamp_word((a * b) >>> FRAC_BITS);
    endfunction

    // Floor of a * 2^FRAC_BITS / b for b > 0.
    function automatic longint fx_div(input longint a, input longint b);
        longint num;
        longint q;
        num = a <<< FRAC_BITS;
        q = num / b;
        if (num % b != 0 && num < 0) q = q - 1;
        return clamp_word(q);
    endfunction

    function automatic t_cval c_mul(input t_cval a, input t_cval b);
        t_cval r;
        r.re = clamp_word(fx_mul(a.re, b.re) - fx_mul(a.im, b.im));
        r.im = clamp_word(fx_mul(a.re, b.im) + fx_mul(a.im, b.re));
        return r;
    endfunction

    function automatic longint rail_of(input longint v);
        if (v > 0) return longint'(WMAX);
        if (v < 0) return longint'(WMIN);
        return 0;
    endfunction

    // A zero or negative squared modulus sends each component to the rail
    // that matches the sign of its numerator.
    function automatic t_cval c_div(input t_cval n, input t_cval d);
        t_cval  r;
        longint m;
        m = clamp_word(fx_mul(d.re, d.re) + fx_mul(d.im, d.im));
        if (m <= 0) begin
            r.re = rail_of(n.re);
            r.im = rail_of(n.im);
        end else begin
            r.re = fx_div(clamp_word(fx_mul(n.re, d.re) + fx_mul(n.im, d.im)), m);
            r.im = fx_div(clamp_word(fx_mul(n.im, d.re) - fx_mul(n.re, d.im)), m);
        end
        return r;
    endfunction

    function automatic t_cval rational_map(input t_cval x, input t_cval a);
        t_cval xm1, t, one_minus_a, c, num, den;
        xm1.re = clamp_word(x.re - longint'(QONE));
        xm1.im = x.im;
        t = c_mul(c_mul(x, x), xm1);
        one_minus_a.re = clamp_word(longint'(QONE) - a.re);
        one_minus_a.im = clamp_word(-a.im);
        c = c_mul(c_mul(a, a), one_minus_a);
        num.re = clamp_word(t.re + c.re);
        num.im = clamp_word(t.im + c.im);
        num = c_mul(a, num);
        den.re = clamp_word(t.re + longint'(QK427));
        den.im = t.im;
        return c_div(num, den);
    endfunction

    function automatic t_outcome orbit_period(input logic signed [31:0] re,
                                              input logic signed [31:0] im);
        t_cval    a, x, o;
        t_cval    orbit[ORBIT_DEPTH];
        int       n, p;
        longint   dr, di, sq_dist;
        t_outcome r;
        n = iter_setting;
        p = plim_setting;
        a.re = re;
        a.im = im;
        if (p > ORBIT_DEPTH) p = ORBIT_DEPTH;
        if (p > n) p = n;
        x = a;
        for (int i = 0; i < n; i++) begin
            if (i >= n - p) orbit[i - (n - p)] = x;
            x = rational_map(x, a);
        end
        r.hit = 1'b0;
        r.lag = '0;
        r.colour = '1;
        // Newest stored iterate first; the first close one wins.
        for (int j = 0; j < p; j++) begin
            o = orbit[p - j - 1];
            dr = clamp_word(x.re - o.re);
            di = clamp_word(x.im - o.im);
            sq_dist = fx_mul(dr, dr) + fx_mul(di, di);
            if (!r.hit && sq_dist < longint'(eps_setting)) begin
                r.hit = 1'b1;
                r.lag = LAG_W'(j);
                r.colour = COLOUR_W'(j) * COLOUR_STEP + COLOUR_BASE;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Result checking. Results cannot be held off, so every o_valid cycle
    // is compared against the oldest outstanding expectation.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (pending_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: hit=%0d lag=%0d colour=%0d",
                             o_hit, o_lag, o_colour_code);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_hit !== want.hit || o_lag !== want.lag ||
                    o_colour_code !== want.colour) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: exp hit=%0d lag=%0d col=%0d got hit=%0d lag=%0d col=%0d",
                                 want.hit, want.lag, want.colour,
                                 o_hit, o_lag, o_colour_code);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers.
    // ---------------------------------------------------------------------

    // Register writes happen only once every request has been answered.
    // The leading edge keeps the enable low for a cycle between two writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        while (pending_outcomes.size() != 0 || busy) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_ITER: iter_setting = data[ITER_W-1:0];
            CFG_PER_LIM:  plim_setting = data[PLIM_W-1:0];
            CFG_EPS:      eps_setting  = data[EPS_W-1:0];
            default: ;
        endcase
    endtask

    // Holds start high until the request is taken. start stays high on
    // return so that a back-to-back request needs no second assignment.
    task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im,
                              input logic known, input t_outcome outcome);
        start      <= 1'b1;
        i_point_re <= re;
        i_point_im <= im;
        do @(posedge i_clk); while (busy);
        pending_outcomes.push_back(known ? outcome : orbit_period(re, im));
    endtask

    // Mostly no gap or a short one, now and then a long pause.
    task automatic idle_gap();
        int gap;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: gap = 0;
            9:          gap = $urandom_range(20, 80);
            default:    gap = $urandom_range(1, 4);
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Points mostly in the interesting square of half-width two, some near the
    // origin or at the rails, the rest over the whole word so that every input bit toggles.
    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
            6:       return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            7:       return $urandom_range(0, 1) ? WMAX : WMIN;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_settings();
        if ($urandom_range(0, 4) == 0)
            write_reg(CFG_MAX_ITER, CFG_W'($urandom_range(40, 100)));
        else
            write_reg(CFG_MAX_ITER, CFG_W'($urandom_range(1, 20)));
        write_reg(CFG_PER_LIM, CFG_W'($urandom_range(0, 127)));
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_EPS, CFG_W'($urandom_range(0, 100000)));
            1:       write_reg(CFG_EPS, CFG_W'(RST_EPS));
            2:       write_reg(CFG_EPS, CFG_W'($urandom_range(0, 32'h1000_0000)));
            default: write_reg(CFG_EPS, CFG_W'($urandom));
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Main sequence.
    // ---------------------------------------------------------------------
    initial begin
        t_row     plan[$];
        t_outcome no_hit;
        t_outcome lag_zero;
        t_outcome dont_care;
        int       tail;

        start         = 1'b0;
        i_point_re    = '0;
        i_point_im    = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_MAX_ITER;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        iter_setting  = RST_MAX_ITER;
        plim_setting  = RST_PER_LIM;
        eps_setting   = RST_EPS;
        mismatch_count = 0;
        cycle_count    = 0;

        no_hit    = '{hit: 1'b0, lag: '0, colour: '1};
        lag_zero  = '{hit: 1'b1, lag: '0, colour: COLOUR_BASE};
        dont_care = '{hit: 1'b0, lag: '0, colour: '0};

        // Directed plan. The origin is a fixed point of the map, so it hits
        // at lag zero whenever the threshold is above zero and a lag is tested.
        plan = '{
            '{ROW_POINT, CFG_MAX_ITER, '0, 32'sd0, 32'sd0, 1'b1, lag_zero},
            '{ROW_POINT, CFG_MAX_ITER, '0, WMAX, WMAX, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, WMIN, WMIN, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, WMAX, WMIN, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, QONE, 32'sd0, 1'b0, dont_care},
            // Unknown index must leave every register alone.
            '{ROW_CFG, 2'd3, 31'd5, '0, '0, 1'b0, dont_care},
            '{ROW_CFG, CFG_MAX_ITER, 31'd1, '0, '0, 1'b0, dont_care},
            '{ROW_CFG, CFG_PER_LIM, 31'd64, '0, '0, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, -32'sd134217728, 32'sd67108864, 1'b0, dont_care},
            // Zero iterations: nothing is stored and no lag is tested.
            '{ROW_CFG, CFG_MAX_ITER, 31'd0, '0, '0, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, 32'sd0, 32'sd0, 1'b1, no_hit},
            // Period limit zero gives no hit even on the fixed point.
            '{ROW_CFG, CFG_MAX_ITER, 31'd5, '0, '0, 1'b0, dont_care},
            '{ROW_CFG, CFG_PER_LIM, 31'd0, '0, '0, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, 32'sd0, 32'sd0, 1'b1, no_hit},
            // Period limit above the orbit depth is clamped to the depth.
            '{ROW_CFG, CFG_MAX_ITER, 31'd70, '0, '0, 1'b0, dont_care},
            '{ROW_CFG, CFG_PER_LIM, 31'd127, '0, '0, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, 32'sd53687091, -32'sd107374182, 1'b0, dont_care},
            // A zero threshold can never be undercut.
            '{ROW_CFG, CFG_EPS, 31'd0, '0, '0, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, 32'sd0, 32'sd0, 1'b1, no_hit},
            '{ROW_CFG, CFG_EPS, 31'h7FFF_FFFF, '0, '0, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, WMIN, WMAX, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, 32'sd0, 32'sd0, 1'b1, lag_zero},
            // Largest iteration count written, then a long but affordable one.
            '{ROW_CFG, CFG_MAX_ITER, 31'd65535, '0, '0, 1'b0, dont_care},
            '{ROW_CFG, CFG_MAX_ITER, 31'd1000, '0, '0, 1'b0, dont_care},
            '{ROW_CFG, CFG_EPS, 31'd26844, '0, '0, 1'b0, dont_care},
            '{ROW_POINT, CFG_MAX_ITER, '0, -32'sd80530636, 32'sd26843545, 1'b0, dont_care}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                start <= 1'b0;
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                send_point(plan[k].re, plan[k].im, plan[k].known, plan[k].outcome);
                idle_gap();
            end
        end

        // Random part: new settings every phase, random points within it.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % PHASE_LEN == 0) begin
                start <= 1'b0;
                random_settings();
            end
            send_point(random_coord(), random_coord(), 1'b0, dont_care);
            idle_gap();
        end
        start <= 1'b0;

        while (pending_outcomes.size() != 0) @(posedge i_clk);
        tail = 200;
        repeat (tail) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
